// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising aclk edge while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that cond at one edge implies nxt at the following edge
`define ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== rtl/bacs_pkg.sv =====
// Types and constants of the brake actuator command sequencer
`timescale 1ns / 1ps
`default_nettype none

package bacs_pkg;

    typedef enum logic [1:0] {
        PH_BOOT     = 2'd0,
        PH_LISTEN   = 2'd1,
        PH_ACTIVE   = 2'd2,
        PH_DEGRADED = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_BOOT_WAIT    = 3'd0,
        REG_SYNC_TIMEOUT = 3'd1,
        REG_ESTOP_STROKE = 3'd2,
        REG_MANUAL_STROKE = 3'd3,
        REG_ZERO_STROKE  = 3'd4,
        REG_MAX_PRESSURE = 3'd5
    } reg_idx_t;

    localparam int APB_AW = 5;

    localparam logic [15:0] RST_BOOT_WAIT    = 16'd50;
    localparam logic [15:0] RST_SYNC_TIMEOUT = 16'd200;
    localparam logic [7:0]  RST_MAX_PRESSURE = 8'd255;

    // Pressure code = (kpa + KPA_ROUND) / KPA_STEP, done as a reciprocal multiply.
    // Exact for every sum below 2**DIV_SHIFT / (rounding error of DIV_MULT).
    localparam logic [15:0] KPA_ROUND = 16'd25;
    localparam int          KPA_STEP  = 50;
    localparam int          DIV_SHIFT = 21;
    localparam logic [15:0] DIV_MULT  = 16'(((1 << DIV_SHIFT) + KPA_STEP - 1) / KPA_STEP);
    localparam int          RAW_W     = 32 - DIV_SHIFT;

endpackage

`default_nettype wire

// ===== rtl/brake_actuator_command_sequencer.sv =====
// Brake actuator command sequencer: phase sequencer, command select, APB registers
// Throughput: one beat per cycle while m_ready does not stall the result register.
// An accepted input beat passes one input register and one result register, with
// the per-tick decision and the 16x16 reciprocal multiply between them.
// Reset (aresetn low, synchronous): phase boot wait, timer, captured stroke and
// rolling counter cleared, registers back to their defaults, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module brake_actuator_command_sequencer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command tick in
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_lever,
    input  wire logic                          s_estop,
    input  wire logic signed [15:0]            s_brake_kpa,
    input  wire logic                          s_fb_valid,
    input  wire logic                          s_fb_alignment,
    input  wire logic [15:0]                   s_fb_stroke,
    // command out
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_cmd_valid,
    output logic                               m_stroke_ctl,
    output logic [15:0]                        m_stroke_cmd,
    output logic [7:0]                         m_pressure_cmd,
    output logic                               m_auto_press,
    output logic [3:0]                         m_rolling_count,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bacs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // ---------------- configuration registers ----------------
    logic [15:0] boot_wait_reg;
    logic [15:0] sync_timeout_reg;
    logic [15:0] estop_stroke_reg;
    logic [15:0] manual_stroke_reg;
    logic [15:0] zero_stroke_reg;
    logic [7:0]  max_pressure_reg;

    bacs_pkg::reg_idx_t cfg_idx;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = bacs_pkg::reg_idx_t'(paddr[bacs_pkg::APB_AW-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_wait_reg     <= bacs_pkg::RST_BOOT_WAIT;
            sync_timeout_reg  <= bacs_pkg::RST_SYNC_TIMEOUT;
            estop_stroke_reg  <= '0;
            manual_stroke_reg <= '0;
            zero_stroke_reg   <= '0;
            max_pressure_reg  <= bacs_pkg::RST_MAX_PRESSURE;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                bacs_pkg::REG_BOOT_WAIT:     boot_wait_reg     <= pwdata[15:0];
                bacs_pkg::REG_SYNC_TIMEOUT:  sync_timeout_reg  <= pwdata[15:0];
                bacs_pkg::REG_ESTOP_STROKE:  estop_stroke_reg  <= pwdata[15:0];
                bacs_pkg::REG_MANUAL_STROKE: manual_stroke_reg <= pwdata[15:0];
                bacs_pkg::REG_ZERO_STROKE:   zero_stroke_reg   <= pwdata[15:0];
                bacs_pkg::REG_MAX_PRESSURE:  max_pressure_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bacs_pkg::REG_BOOT_WAIT:     prdata = {16'b0, boot_wait_reg};
            bacs_pkg::REG_SYNC_TIMEOUT:  prdata = {16'b0, sync_timeout_reg};
            bacs_pkg::REG_ESTOP_STROKE:  prdata = {16'b0, estop_stroke_reg};
            bacs_pkg::REG_MANUAL_STROKE: prdata = {16'b0, manual_stroke_reg};
            bacs_pkg::REG_ZERO_STROKE:   prdata = {16'b0, zero_stroke_reg};
            bacs_pkg::REG_MAX_PRESSURE:  prdata = {24'b0, max_pressure_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- handshake and input register ----------------
    logic        in_valid_reg;
    logic        in_lever_reg;
    logic        in_estop_reg;
    logic [15:0] in_kpa_reg;
    logic        in_fbv_reg;
    logic        in_fba_reg;
    logic [15:0] in_fbs_reg;

    logic out_free;
    logic advance;

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_lever_reg <= s_lever;
            in_estop_reg <= s_estop;
            in_kpa_reg   <= s_brake_kpa;
            in_fbv_reg   <= s_fb_valid;
            in_fba_reg   <= s_fb_alignment;
            in_fbs_reg   <= s_fb_stroke;
        end
    end

    // ---------------- sequencer state ----------------
    bacs_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      timer_reg, timer_next;
    logic [15:0]      captured_reg, captured_next;
    logic [3:0]       roll_reg, roll_next;

    logic [15:0] timer_inc;
    logic [15:0] captured_eff;
    logic        fb_aligned;

    assign timer_inc  = timer_reg + 16'd1;
    assign fb_aligned = in_fbv_reg && in_fba_reg;
    // the first nonzero stroke seen in listen sticks
    assign captured_eff = (in_fbv_reg && captured_reg == 16'd0) ? in_fbs_reg : captured_reg;

    always_comb begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        captured_next = captured_reg;
        unique case (phase_reg)
            bacs_pkg::PH_BOOT: begin
                timer_next = timer_inc;
                if (timer_inc >= boot_wait_reg) begin
                    phase_next = bacs_pkg::PH_LISTEN;
                    timer_next = '0;
                end
            end
            bacs_pkg::PH_LISTEN: begin
                captured_next = captured_eff;
                if (fb_aligned) begin
                    phase_next = bacs_pkg::PH_ACTIVE;
                end else begin
                    timer_next = timer_inc;
                    if (timer_inc >= sync_timeout_reg) begin
                        phase_next = bacs_pkg::PH_DEGRADED;
                    end
                end
            end
            bacs_pkg::PH_ACTIVE: ;
            bacs_pkg::PH_DEGRADED: begin
                if (fb_aligned) begin
                    phase_next = bacs_pkg::PH_ACTIVE;
                end
            end
        endcase
    end

    // ---------------- command selection ----------------
    logic issue;
    logic use_sync;
    logic kpa_ignore;

    always_comb begin
        issue      = 1'b0;
        use_sync   = 1'b0;
        kpa_ignore = 1'b0;
        unique case (phase_reg)
            bacs_pkg::PH_BOOT: ;
            bacs_pkg::PH_LISTEN: begin
                if (fb_aligned) begin
                    issue    = 1'b1;
                    use_sync = 1'b1;
                end else if (timer_inc >= sync_timeout_reg) begin
                    issue      = 1'b1;
                    kpa_ignore = 1'b1;
                end
            end
            bacs_pkg::PH_ACTIVE: issue = 1'b1;
            bacs_pkg::PH_DEGRADED: begin
                issue      = 1'b1;
                kpa_ignore = 1'b1;
            end
        endcase
    end

    // pressure = (kpa + 25) / 50 for positive kpa, through a reciprocal multiply
    logic                       kpa_pos;
    logic [15:0]                kpa_sum;
    logic [31:0]                div_prod;
    logic [bacs_pkg::RAW_W-1:0] press_raw;
    logic [7:0]                 press_sat;

    assign kpa_pos   = !in_kpa_reg[15] && (in_kpa_reg != 16'd0) && !kpa_ignore;
    assign kpa_sum   = {1'b0, in_kpa_reg[14:0]} + bacs_pkg::KPA_ROUND;
    assign div_prod  = {16'b0, kpa_sum} * {16'b0, bacs_pkg::DIV_MULT};
    assign press_raw = div_prod[31:bacs_pkg::DIV_SHIFT];
    assign press_sat = (press_raw > {{(bacs_pkg::RAW_W-8){1'b0}}, max_pressure_reg})
                       ? max_pressure_reg : press_raw[7:0];

    logic        mode_c;
    logic [15:0] stroke_c;
    logic [7:0]  press_c;
    logic        auto_c;

    always_comb begin
        mode_c   = 1'b1;
        stroke_c = zero_stroke_reg;
        press_c  = '0;
        auto_c   = 1'b0;
        priority if (use_sync && captured_eff != 16'd0) begin
            stroke_c = captured_eff;
        end else if (in_estop_reg) begin
            stroke_c = estop_stroke_reg;
        end else if (in_lever_reg) begin
            stroke_c = manual_stroke_reg;
        end else if (kpa_pos) begin
            mode_c  = 1'b0;
            press_c = press_sat;
            auto_c  = 1'b1;
        end else begin
            stroke_c = zero_stroke_reg;
        end
    end

    assign roll_next = issue ? roll_reg + 4'd1 : roll_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= bacs_pkg::PH_BOOT;
            timer_reg    <= '0;
            captured_reg <= '0;
            roll_reg     <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            captured_reg <= captured_next;
            roll_reg     <= roll_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_cmd_valid     <= issue;
            m_stroke_ctl    <= issue && mode_c;
            m_stroke_cmd    <= issue ? stroke_c : 16'd0;
            m_pressure_cmd  <= issue ? press_c : 8'd0;
            m_auto_press    <= issue && auto_c;
            m_rolling_count <= issue ? roll_reg : 4'd0;
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_idle_result_zero,
        !(m_valid && !m_cmd_valid) || (!m_stroke_ctl && m_stroke_cmd == 16'd0 &&
        m_pressure_cmd == 8'd0 && !m_auto_press && m_rolling_count == 4'd0),
        "result without command carries nonzero fields")
    `ASSERT_NEXT(a_active_sticks, phase_reg == bacs_pkg::PH_ACTIVE,
        phase_reg == bacs_pkg::PH_ACTIVE, "sequencer left active phase")
    `ASSERT_NEXT(a_roll_only_on_issue, !(advance && issue), $stable(roll_reg),
        "rolling counter moved without an issued command")
    `ASSERT_CLK(a_auto_is_pressure,
        !(m_valid && m_auto_press) || (m_cmd_valid && !m_stroke_ctl),
        "automated brake result not in pressure mode")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the brake actuator command sequencer: phase walk, command priority, pressure math
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int GAP_MAX     = 12;

    typedef struct packed {
        logic        lever;
        logic        estop;
        logic [15:0] kpa;
        logic        fb_valid;
        logic        fb_alignment;
        logic [15:0] fb_stroke;
    } tick_t;

    typedef struct packed {
        logic        cmd_valid;
        logic        stroke_ctl;
        logic [15:0] stroke_cmd;
        logic [7:0]  pressure_cmd;
        logic        auto_press;
        logic [3:0]  rolling_count;
    } cmd_t;

    typedef enum {SYNC_CAPTURED, SYNC_LATE_CAPTURE, SYNC_NONE, SYNC_TIMEOUT} sync_path_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_lever;
    logic        s_estop;
    logic [15:0] s_brake_kpa;
    logic        s_fb_valid;
    logic        s_fb_alignment;
    logic [15:0] s_fb_stroke;
    logic        m_valid;
    logic        m_ready;
    logic        m_cmd_valid;
    logic        m_stroke_ctl;
    logic [15:0] m_stroke_cmd;
    logic [7:0]  m_pressure_cmd;
    logic        m_auto_press;
    logic [3:0]  m_rolling_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [bacs_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    brake_actuator_command_sequencer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_lever        (s_lever),
        .s_estop        (s_estop),
        .s_brake_kpa    (s_brake_kpa),
        .s_fb_valid     (s_fb_valid),
        .s_fb_alignment (s_fb_alignment),
        .s_fb_stroke    (s_fb_stroke),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cmd_valid    (m_cmd_valid),
        .m_stroke_ctl   (m_stroke_ctl),
        .m_stroke_cmd   (m_stroke_cmd),
        .m_pressure_cmd (m_pressure_cmd),
        .m_auto_press   (m_auto_press),
        .m_rolling_count(m_rolling_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Sequencer copy: configuration and state as the block should hold them
    logic [15:0]      cfg_boot_wait     = bacs_pkg::RST_BOOT_WAIT;
    logic [15:0]      cfg_sync_timeout  = bacs_pkg::RST_SYNC_TIMEOUT;
    logic [15:0]      cfg_estop_stroke  = '0;
    logic [15:0]      cfg_manual_stroke = '0;
    logic [15:0]      cfg_zero_stroke   = '0;
    logic [7:0]       cfg_max_pressure  = bacs_pkg::RST_MAX_PRESSURE;
    bacs_pkg::phase_t seq_phase         = bacs_pkg::PH_BOOT;
    logic [15:0]      seq_timer         = '0;
    logic [15:0]      seq_captured      = '0;
    logic [3:0]       seq_roll          = '0;

    cmd_t       expected_cmds[$];
    cmd_t       want;
    bit         s_valid_held;
    int         in_gap_max = GAP_MAX;
    int         rx_gap_max = GAP_MAX;
    int         rx_hold_cycles;
    int         errors;
    int         ticks_sent;
    int         results_seen;
    int         cmds_issued;
    int         pressure_cmds;
    int         captured_cmds;
    int         cycle_count;
    sync_path_t sync_path;

    function automatic cmd_t build_cmd(bit use_capture, tick_t t, int kpa);
        cmd_t c;
        int   raw;
        c = '0;
        c.cmd_valid  = 1'b1;
        c.stroke_ctl = 1'b1;
        if (use_capture && seq_captured != 16'd0) begin
            c.stroke_cmd = seq_captured;
            captured_cmds++;
        end else if (t.estop) begin
            c.stroke_cmd = cfg_estop_stroke;
        end else if (t.lever) begin
            c.stroke_cmd = cfg_manual_stroke;
        end else if (kpa > 0) begin
            raw = (kpa + 25) / 50;
            c.stroke_ctl   = 1'b0;
            c.stroke_cmd   = cfg_zero_stroke;
            c.pressure_cmd = (raw > int'(cfg_max_pressure)) ? cfg_max_pressure : raw[7:0];
            c.auto_press   = 1'b1;
            pressure_cmds++;
        end else begin
            c.stroke_cmd = cfg_zero_stroke;
        end
        c.rolling_count = seq_roll;
        seq_roll = seq_roll + 4'd1;
        cmds_issued++;
        return c;
    endfunction

    function automatic cmd_t predict_cmd(tick_t t);
        cmd_t c;
        int   kpa;
        c   = '0;
        kpa = $signed(t.kpa);
        case (seq_phase)
            bacs_pkg::PH_BOOT: begin
                seq_timer = seq_timer + 16'd1;
                if (seq_timer >= cfg_boot_wait) begin
                    seq_phase = bacs_pkg::PH_LISTEN;
                    seq_timer = '0;
                end
            end
            bacs_pkg::PH_LISTEN: begin
                if (t.fb_valid && seq_captured == 16'd0)
                    seq_captured = t.fb_stroke;
                if (t.fb_valid && t.fb_alignment) begin
                    seq_phase = bacs_pkg::PH_ACTIVE;
                    c = build_cmd(1'b1, t, kpa);
                end else begin
                    seq_timer = seq_timer + 16'd1;
                    // timeout drops the pressure request on the way into degraded
                    if (seq_timer >= cfg_sync_timeout) begin
                        seq_phase = bacs_pkg::PH_DEGRADED;
                        c = build_cmd(1'b0, t, 0);
                    end
                end
            end
            bacs_pkg::PH_ACTIVE: c = build_cmd(1'b0, t, kpa);
            default: begin
                if (t.fb_valid && t.fb_alignment)
                    seq_phase = bacs_pkg::PH_ACTIVE;
                c = build_cmd(1'b0, t, 0);
            end
        endcase
        return c;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= 20)
            $display("ERROR t=%0t: %s", $time, msg);
    endtask

    task automatic check_field(string field, int got, int exp_val);
        if (got != exp_val)
            report_error($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                   results_seen, field, got, exp_val));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_cmds.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                want = expected_cmds.pop_front();
                check_field("cmd_valid", m_cmd_valid, want.cmd_valid);
                check_field("stroke_ctl", m_stroke_ctl, want.stroke_ctl);
                check_field("stroke_cmd", m_stroke_cmd, want.stroke_cmd);
                check_field("pressure_cmd", m_pressure_cmd, want.pressure_cmd);
                check_field("auto_press", m_auto_press, want.auto_press);
                check_field("rolling_count", m_rolling_count, want.rolling_count);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_cmds.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stall per beat, plus a long hold-off on request
    initial begin : rx_side
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles != 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic idle_input();
        if (s_valid_held) begin
            s_valid <= 1'b0;
            s_valid_held = 1'b0;
        end
    endtask

    // Valid stays high after a beat so that a zero-gap beat follows without a drop
    task automatic send_tick(tick_t t);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            idle_input();
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_lever        <= t.lever;
        s_estop        <= t.estop;
        s_brake_kpa    <= t.kpa;
        s_fb_valid     <= t.fb_valid;
        s_fb_alignment <= t.fb_alignment;
        s_fb_stroke    <= t.fb_stroke;
        s_valid_held = 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_cmds.push_back(predict_cmd(t));
        ticks_sent++;
    endtask

    task automatic wait_idle();
        idle_input();
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(bacs_pkg::reg_idx_t idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper bits are junk: the registers keep only their own width
        if (idx == bacs_pkg::REG_MAX_PRESSURE)
            pwdata <= {24'($urandom), val[7:0]};
        else
            pwdata <= {16'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bacs_pkg::REG_BOOT_WAIT:     cfg_boot_wait     = val;
            bacs_pkg::REG_SYNC_TIMEOUT:  cfg_sync_timeout  = val;
            bacs_pkg::REG_ESTOP_STROKE:  cfg_estop_stroke  = val;
            bacs_pkg::REG_MANUAL_STROKE: cfg_manual_stroke = val;
            bacs_pkg::REG_ZERO_STROKE:   cfg_zero_stroke   = val;
            default:                     cfg_max_pressure  = val[7:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_strokes(logic [15:0] estop_s, logic [15:0] manual_s,
                               logic [15:0] zero_s, logic [7:0] max_p);
        wait_idle();
        reg_write(bacs_pkg::REG_ESTOP_STROKE, estop_s);
        reg_write(bacs_pkg::REG_MANUAL_STROKE, manual_s);
        reg_write(bacs_pkg::REG_ZERO_STROKE, zero_s);
        reg_write(bacs_pkg::REG_MAX_PRESSURE, {8'd0, max_p});
    endtask

    function automatic tick_t make_tick(logic lever, logic estop, int kpa,
                                        logic fbv, logic fba, logic [15:0] stroke);
        tick_t t;
        t.lever        = lever;
        t.estop        = estop;
        t.kpa          = kpa[15:0];
        t.fb_valid     = fbv;
        t.fb_alignment = fba;
        t.fb_stroke    = stroke;
        return t;
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.lever = ($urandom_range(0, 3) == 0);
        t.estop = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 3))
            0:       t.kpa = 16'($urandom);
            1:       t.kpa = 16'($urandom_range(1, 13000));
            2:       t.kpa = 16'($urandom_range(0, 100));
            default: t.kpa = 16'(0 - int'($urandom_range(0, 2000)));
        endcase
        t.fb_valid     = 1'($urandom_range(0, 1));
        t.fb_alignment = 1'($urandom_range(0, 1));
        t.fb_stroke    = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        return t;
    endfunction

    task automatic test_boot_wait();
        repeat (3) send_tick(rand_tick());
        wait_idle();
        reg_write(bacs_pkg::REG_BOOT_WAIT, 16'hFFFF);
        repeat (4) send_tick(rand_tick());
        // limit below the running count: leave boot wait on the next tick
        wait_idle();
        reg_write(bacs_pkg::REG_BOOT_WAIT, 16'd0);
        send_tick(make_tick(1'b1, 1'b1, 4000, 1'b1, 1'b1, 16'h1357));
    endtask

    task automatic test_sync_listen();
        logic [15:0] first_stroke;
        first_stroke = 16'($urandom_range(1, 65535));
        set_strokes(16'($urandom), 16'($urandom), 16'($urandom), 8'd255);
        reg_write(bacs_pkg::REG_SYNC_TIMEOUT, 16'hFFFF);
        send_tick(make_tick(1'b0, 1'b0, 1000, 1'b0, 1'b1, 16'h5A5A));
        send_tick(make_tick(1'b1, 1'b0, 500, 1'b1, 1'b0, 16'd0));
        if (sync_path == SYNC_CAPTURED || sync_path == SYNC_TIMEOUT) begin
            send_tick(make_tick(1'b0, 1'b0, 0, 1'b1, 1'b0, first_stroke));
            send_tick(make_tick(1'b0, 1'b1, 0, 1'b1, 1'b0, ~first_stroke));
        end
        if (sync_path == SYNC_TIMEOUT) begin
            wait_idle();
            reg_write(bacs_pkg::REG_SYNC_TIMEOUT, 16'd0);
            send_tick(make_tick(1'b0, 1'b0, 1000, 1'b0, 1'b0, 16'd0));
        end else begin
            send_tick(make_tick(1'b1, 1'b1, 3000, 1'b1, 1'b1,
                                (sync_path == SYNC_NONE) ? 16'd0 : 16'($urandom_range(1, 65535))));
        end
    endtask

    task automatic test_degraded();
        tick_t t;
        if (seq_phase != bacs_pkg::PH_DEGRADED)
            return;
        repeat (60) begin
            t = rand_tick();
            t.fb_alignment = 1'b0;
            send_tick(t);
        end
        // aligned frame: still a degraded command, active from the next tick
        send_tick(make_tick(1'b0, 1'b0, 2000, 1'b1, 1'b1, 16'hBEEF));
        send_tick(make_tick(1'b0, 1'b0, 2000, 1'b0, 1'b0, 16'd0));
    endtask

    task automatic test_command_priority();
        int kpa_list[13] = '{32767, -32768, 0, 1, 24, 25, 74, 75,
                             12724, 12725, 12775, -1, 1000};
        set_strokes(16'hFFFF, 16'h8000, 16'h0001, 8'd255);
        send_tick(make_tick(1'b1, 1'b1, 1000, 1'b0, 1'b0, 16'd0));
        send_tick(make_tick(1'b1, 1'b0, 1000, 1'b1, 1'b1, 16'hFFFF));
        foreach (kpa_list[i])
            send_tick(make_tick(1'b0, 1'b0, kpa_list[i], 1'b0, 1'b0, 16'd0));
        set_strokes(16'h0000, 16'h0000, 16'hFFFF, 8'd0);
        send_tick(make_tick(1'b0, 1'b0, 500, 1'b0, 1'b0, 16'd0));
        set_strokes(16'h00FF, 16'hFF00, 16'h0F0F, 8'd100);
        send_tick(make_tick(1'b0, 1'b0, 4975, 1'b0, 1'b0, 16'd0));
        send_tick(make_tick(1'b0, 1'b0, 5025, 1'b0, 1'b0, 16'd0));
    endtask

    task automatic test_random_settings(int first, int count);
        for (int s = first; s < first + count; s++) begin
            case (s)
                0:       set_strokes(16'h0000, 16'h0000, 16'h0000, 8'd0);
                1:       set_strokes(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
                default: set_strokes(16'($urandom), 16'($urandom), 16'($urandom),
                                     8'($urandom_range(0, 255)));
            endcase
            in_gap_max = (s % 3 == 1) ? 0 : GAP_MAX;
            rx_gap_max = (s % 4 == 2) ? 0 : GAP_MAX;
            repeat (200) send_tick(rand_tick());
        end
        in_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
    endtask

    task automatic test_backpressure();
        wait_idle();
        rx_hold_cycles = 300;
        in_gap_max = 0;
        repeat (40) send_tick(rand_tick());
        in_gap_max = GAP_MAX;
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_lever        <= 1'b0;
        s_estop        <= 1'b0;
        s_brake_kpa    <= '0;
        s_fb_valid     <= 1'b0;
        s_fb_alignment <= 1'b0;
        s_fb_stroke    <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        sync_path = sync_path_t'($urandom_range(0, 3));
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_boot_wait();
        test_sync_listen();
        test_degraded();
        test_command_priority();
        test_random_settings(0, 4);
        test_backpressure();
        test_random_settings(4, 4);

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("covered %0d ticks via sync path %s: %0d commands, %0d pressure, %0d captured",
                 ticks_sent, sync_path.name(), cmds_issued, pressure_cmds, captured_cmds);
        $display("checked %0d results, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bacs_pkg.sv
rtl/brake_actuator_command_sequencer.sv
dv/tb_top.sv
